[sv/pcs_pkg.sv]
// Shared types, constants and helpers for the clamped Euler step unit.
// No dependencies; used by pcs_clamp and particle_clamped_euler_step_unit.
`default_nettype none

package pcs_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd2;

    // Register reset values (unsigned Q16.16).
    localparam logic [30:0] MAX_ACCEL_RST = 31'd65536;
    localparam logic [30:0] MAX_SPEED_RST = 31'd65536;
    localparam logic [30:0] TIME_STEP_RST = 31'd1092;

    // Iteration counts of the length clamp: one root bit and one quotient bit per stage.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    // Width of the item fields that ride alongside a clamp unit.
    localparam int SIDE_W = 129;

    // Sign-extend a 32-bit word to the 50-bit accumulator width.
    function automatic logic [49:0] sx50(input logic [31:0] v);
        return {{18{v[31]}}, v};
    endfunction

    // Saturate a 50-bit two's complement value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [49:0] v);
        logic [31:0] r;
        if (v[49:31] == {19{v[49]}})
        begin
            r = v[31:0];
        end
        else if (v[49])
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/pcs_clamp.sv]
// Pipelined vector length clamp: squares, digit-per-stage square root and
// digit-per-stage division. Depends on pcs_pkg.
`default_nettype none

module pcs_clamp #(
    parameter int SIDE_W = 129
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [31:0]       in_x,
    input  wire logic [31:0]       in_y,
    input  wire logic [SIDE_W-1:0] in_side,
    input  wire logic [30:0]       lim,
    output logic                   out_vld,
    output logic [31:0]            out_x,
    output logic [31:0]            out_y,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int SQ_N  = pcs_pkg::SQRT_STEPS;
    localparam int DIV_N = pcs_pkg::DIV_STEPS;

    typedef struct packed {
        logic              gt;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [62:0]       nx;
        logic [62:0]       ny;
        logic [SIDE_W-1:0] side;
    } carry_t;

    // Stage A: magnitudes.
    logic              a_vld_reg;
    logic [31:0]       a_x_reg, a_y_reg, a_ux_reg, a_uy_reg;
    logic [SIDE_W-1:0] a_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg    <= in_x;
            a_y_reg    <= in_y;
            a_ux_reg   <= in_x[31] ? (32'd0 - in_x) : in_x;
            a_uy_reg   <= in_y[31] ? (32'd0 - in_y) : in_y;
            a_side_reg <= in_side;
        end
    end

    // Stage B: squares, squared limit and limit-scaled magnitudes.
    logic              b_vld_reg;
    logic [63:0]       b_sqx_reg, b_sqy_reg;
    logic [61:0]       b_m2_reg;
    logic [62:0]       b_nx_reg, b_ny_reg;
    logic [31:0]       b_x_reg, b_y_reg;
    logic [SIDE_W-1:0] b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_sqx_reg  <= a_ux_reg * a_ux_reg;
            b_sqy_reg  <= a_uy_reg * a_uy_reg;
            b_m2_reg   <= lim * lim;
            b_nx_reg   <= lim * a_ux_reg;
            b_ny_reg   <= lim * a_uy_reg;
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
            b_side_reg <= a_side_reg;
        end
    end

    // Square root pipeline; entry 0 holds the squared length and the rescale decision.
    logic        sq_vld_reg [0:SQ_N];
    carry_t      sq_c_reg   [0:SQ_N];
    logic [63:0] sq_s_reg   [0:SQ_N];
    logic [31:0] sq_r_reg   [0:SQ_N];
    logic [32:0] sq_rem_reg [0:SQ_N];
    logic [63:0] s_sum;

    assign s_sum = b_sqx_reg + b_sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg[0] <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_c_reg[0].gt   <= s_sum > {2'b00, b_m2_reg};
            sq_c_reg[0].x    <= b_x_reg;
            sq_c_reg[0].y    <= b_y_reg;
            sq_c_reg[0].nx   <= b_nx_reg;
            sq_c_reg[0].ny   <= b_ny_reg;
            sq_c_reg[0].side <= b_side_reg;
            sq_s_reg[0]      <= s_sum;
            sq_r_reg[0]      <= 32'd0;
            sq_rem_reg[0]    <= 33'd0;
        end
    end

    // One root bit per stage: bring down two radicand bits and try (4r + 1).
    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        logic [34:0] t;
        logic [34:0] trial;
        logic        ge;

        assign t     = {sq_rem_reg[k], sq_s_reg[k][63-2*k -: 2]};
        assign trial = {1'b0, sq_r_reg[k], 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_c_reg[k+1]   <= sq_c_reg[k];
                sq_s_reg[k+1]   <= sq_s_reg[k];
                sq_r_reg[k+1]   <= {sq_r_reg[k][30:0], ge};
                sq_rem_reg[k+1] <= ge ? 33'(t - trial) : t[32:0];
            end
        end
    end

    // Division pipeline: entry 0 is the set-up taken straight from the root.
    logic        dv_vld [0:DIV_N];
    carry_t      dv_c   [0:DIV_N];
    logic [31:0] dv_len [0:DIV_N];
    logic [31:0] dv_rx  [0:DIV_N];
    logic [31:0] dv_ry  [0:DIV_N];
    logic [30:0] dv_qx  [0:DIV_N];
    logic [30:0] dv_qy  [0:DIV_N];

    assign dv_vld[0] = sq_vld_reg[SQ_N];
    assign dv_c[0]   = sq_c_reg[SQ_N];
    assign dv_len[0] = (sq_r_reg[SQ_N] == 32'd0) ? 32'd1 : sq_r_reg[SQ_N];
    assign dv_rx[0]  = sq_c_reg[SQ_N].nx[62:31];
    assign dv_ry[0]  = sq_c_reg[SQ_N].ny[62:31];
    assign dv_qx[0]  = 31'd0;
    assign dv_qy[0]  = 31'd0;

    // One quotient bit per stage for each component, restoring form.
    for (genvar j = 0; j < DIV_N; j++)
    begin : g_div
        logic        vld_reg;
        carry_t      c_reg;
        logic [31:0] len_reg, rx_reg, ry_reg;
        logic [30:0] qx_reg, qy_reg;
        logic [32:0] tx, ty, dl;
        logic        gex, gey;

        assign dl  = {1'b0, dv_len[j]};
        assign tx  = {dv_rx[j], dv_c[j].nx[DIV_N-1-j]};
        assign ty  = {dv_ry[j], dv_c[j].ny[DIV_N-1-j]};
        assign gex = tx >= dl;
        assign gey = ty >= dl;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= dv_vld[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_reg   <= dv_c[j];
                len_reg <= dv_len[j];
                rx_reg  <= gex ? 32'(tx - dl) : tx[31:0];
                ry_reg  <= gey ? 32'(ty - dl) : ty[31:0];
                qx_reg  <= {dv_qx[j][29:0], gex};
                qy_reg  <= {dv_qy[j][29:0], gey};
            end
        end

        assign dv_vld[j+1] = vld_reg;
        assign dv_c[j+1]   = c_reg;
        assign dv_len[j+1] = len_reg;
        assign dv_rx[j+1]  = rx_reg;
        assign dv_ry[j+1]  = ry_reg;
        assign dv_qx[j+1]  = qx_reg;
        assign dv_qy[j+1]  = qy_reg;
    end

    // Output stage: pick the rescaled or the original vector.
    logic              o_vld_reg;
    logic              o_gt_reg;
    logic [31:0]       o_x_reg, o_y_reg;
    logic [SIDE_W-1:0] o_side_reg;
    logic [31:0]       qx_w, qy_w, rx_w, ry_w;

    always_comb
    begin
        qx_w = {1'b0, dv_qx[DIV_N]};
        qy_w = {1'b0, dv_qy[DIV_N]};
        rx_w = dv_c[DIV_N].x;
        ry_w = dv_c[DIV_N].y;
        if (dv_c[DIV_N].gt)
        begin
            rx_w = dv_c[DIV_N].x[31] ? (32'd0 - qx_w) : qx_w;
            ry_w = dv_c[DIV_N].y[31] ? (32'd0 - qy_w) : qy_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            o_vld_reg <= dv_vld[DIV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_gt_reg   <= dv_c[DIV_N].gt;
            o_x_reg    <= rx_w;
            o_y_reg    <= ry_w;
            o_side_reg <= dv_c[DIV_N].side;
        end
    end

    assign out_vld  = o_vld_reg;
    assign out_x    = o_x_reg;
    assign out_y    = o_y_reg;
    assign out_side = o_side_reg;

    // Magnitudes of the output vector, for checking only.
    logic [31:0] mag_x, mag_y;
    assign mag_x = o_x_reg[31] ? (32'd0 - o_x_reg) : o_x_reg;
    assign mag_y = o_y_reg[31] ? (32'd0 - o_y_reg) : o_y_reg;

    // The root stage leaves a value whose square does not exceed the radicand.
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg[SQ_N] |-> (64'(sq_r_reg[SQ_N]) * 64'(sq_r_reg[SQ_N])
                              <= sq_s_reg[SQ_N]))
        else $error("square root stage overshoots the radicand");

    // A rescaled vector never has a component longer than the limit.
    a_rescale_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && o_gt_reg) |-> (mag_x <= {1'b0, lim} && mag_y <= {1'b0, lim}))
        else $error("rescaled component exceeds the limit");

    // A frozen pipeline keeps its output item.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && o_vld_reg) |=> (o_vld_reg && $stable(o_x_reg) && $stable(o_y_reg)))
        else $error("output item changed while the pipeline was held");

endmodule

`default_nettype wire

[sv/particle_clamped_euler_step_unit.sv]
// Top level of the clamped semi-implicit Euler step unit.
// Depends on pcs_pkg and pcs_clamp.
`default_nettype none

// One particle enters per clock while in_stall is low: a register sums the
// forces, each of the two length clamps (acceleration, then velocity) contains
// a 32-stage square root and a 31-stage divider, each clamp is followed by a
// registered time-step multiply and a registered saturating add, and the last
// add lands in the output register. The whole pipeline holds while a result
// waits under out_stall; in_stall is high then. Configuration writes are
// always accepted and must only be made while the pipeline is empty.
module particle_clamped_euler_step_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // Particle input channel.
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] force_a_x,
    input  wire logic [31:0] force_a_y,
    input  wire logic [31:0] force_b_x,
    input  wire logic [31:0] force_b_y,
    input  wire logic [31:0] force_c_x,
    input  wire logic [31:0] force_c_y,
    input  wire logic [31:0] vel_in_x,
    input  wire logic [31:0] vel_in_y,
    input  wire logic [31:0] pos_in_x,
    input  wire logic [31:0] pos_in_y,
    input  wire logic        last_in,
    // Result channel.
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      accel_out_x,
    output logic [31:0]      accel_out_y,
    output logic [31:0]      vel_out_x,
    output logic [31:0]      vel_out_y,
    output logic [31:0]      pos_out_x,
    output logic [31:0]      pos_out_y,
    output logic             last_out
);

    localparam int SW = pcs_pkg::SIDE_W;

    // Configuration registers.
    logic [30:0] max_accel_reg, max_speed_reg, time_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accel_reg <= pcs_pkg::MAX_ACCEL_RST;
            max_speed_reg <= pcs_pkg::MAX_SPEED_RST;
            time_step_reg <= pcs_pkg::TIME_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcs_pkg::REG_MAX_ACCEL: max_accel_reg <= cfg_data[30:0];
                pcs_pkg::REG_MAX_SPEED: max_speed_reg <= cfg_data[30:0];
                pcs_pkg::REG_TIME_STEP: time_step_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves unless a finished result is held by the consumer.
    logic en;
    logic out_vld_reg;

    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    logic signed [31:0] dt_s;
    assign dt_s = {1'b0, time_step_reg};

    // Stage 1: force sum, saturated once.
    logic          s1_vld_reg;
    logic [31:0]   s1_ax_reg, s1_ay_reg;
    logic [SW-1:0] s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ax_reg <= pcs_pkg::sat32(pcs_pkg::sx50(force_a_x) + pcs_pkg::sx50(force_b_x)
                                        + pcs_pkg::sx50(force_c_x));
            s1_ay_reg <= pcs_pkg::sat32(pcs_pkg::sx50(force_a_y) + pcs_pkg::sx50(force_b_y)
                                        + pcs_pkg::sx50(force_c_y));
            s1_side_reg <= {vel_in_x, vel_in_y, pos_in_x, pos_in_y, last_in};
        end
    end

    // Acceleration clamp.
    logic          ca_vld;
    logic [31:0]   ca_x, ca_y;
    logic [SW-1:0] ca_side;

    pcs_clamp #(
        .SIDE_W (SW)
    ) u_clamp_accel (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s1_vld_reg),
        .in_x     (s1_ax_reg),
        .in_y     (s1_ay_reg),
        .in_side  (s1_side_reg),
        .lim      (max_accel_reg),
        .out_vld  (ca_vld),
        .out_x    (ca_x),
        .out_y    (ca_y),
        .out_side (ca_side)
    );

    // Stage 2: acceleration times time step.
    logic          s2_vld_reg;
    logic [63:0]   s2_px_reg, s2_py_reg;
    logic [31:0]   s2_ax_reg, s2_ay_reg;
    logic [SW-1:0] s2_side_reg;
    logic signed [31:0] ca_xs, ca_ys;
    logic signed [63:0] s2_px_next, s2_py_next;

    assign ca_xs      = ca_x;
    assign ca_ys      = ca_y;
    assign s2_px_next = ca_xs * dt_s;
    assign s2_py_next = ca_ys * dt_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= ca_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_px_reg   <= s2_px_next;
            s2_py_reg   <= s2_py_next;
            s2_ax_reg   <= ca_x;
            s2_ay_reg   <= ca_y;
            s2_side_reg <= ca_side;
        end
    end

    // Stage 3: velocity update with floor of the scaled product, saturated.
    logic          s3_vld_reg;
    logic [31:0]   s3_vx_reg, s3_vy_reg;
    logic [SW-1:0] s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_vx_reg <= pcs_pkg::sat32(pcs_pkg::sx50(s2_side_reg[128:97])
                                        + {{2{s2_px_reg[63]}}, s2_px_reg[63:16]});
            s3_vy_reg <= pcs_pkg::sat32(pcs_pkg::sx50(s2_side_reg[96:65])
                                        + {{2{s2_py_reg[63]}}, s2_py_reg[63:16]});
            s3_side_reg <= {s2_ax_reg, s2_ay_reg, s2_side_reg[64:0]};
        end
    end

    // Velocity clamp.
    logic          cv_vld;
    logic [31:0]   cv_x, cv_y;
    logic [SW-1:0] cv_side;

    pcs_clamp #(
        .SIDE_W (SW)
    ) u_clamp_vel (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s3_vld_reg),
        .in_x     (s3_vx_reg),
        .in_y     (s3_vy_reg),
        .in_side  (s3_side_reg),
        .lim      (max_speed_reg),
        .out_vld  (cv_vld),
        .out_x    (cv_x),
        .out_y    (cv_y),
        .out_side (cv_side)
    );

    // Stage 4: velocity times time step.
    logic          s4_vld_reg;
    logic [63:0]   s4_px_reg, s4_py_reg;
    logic [31:0]   s4_vx_reg, s4_vy_reg;
    logic [SW-1:0] s4_side_reg;
    logic signed [31:0] cv_xs, cv_ys;
    logic signed [63:0] s4_px_next, s4_py_next;

    assign cv_xs      = cv_x;
    assign cv_ys      = cv_y;
    assign s4_px_next = cv_xs * dt_s;
    assign s4_py_next = cv_ys * dt_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_vld_reg <= cv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_px_reg   <= s4_px_next;
            s4_py_reg   <= s4_py_next;
            s4_vx_reg   <= cv_x;
            s4_vy_reg   <= cv_y;
            s4_side_reg <= cv_side;
        end
    end

    // Stage 5: position update into the output register.
    logic [31:0] out_ax_reg, out_ay_reg, out_vx_reg, out_vy_reg, out_px_reg, out_py_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ax_reg   <= s4_side_reg[128:97];
            out_ay_reg   <= s4_side_reg[96:65];
            out_vx_reg   <= s4_vx_reg;
            out_vy_reg   <= s4_vy_reg;
            out_px_reg   <= pcs_pkg::sat32(pcs_pkg::sx50(s4_side_reg[64:33])
                                           + {{2{s4_px_reg[63]}}, s4_px_reg[63:16]});
            out_py_reg   <= pcs_pkg::sat32(pcs_pkg::sx50(s4_side_reg[32:1])
                                           + {{2{s4_py_reg[63]}}, s4_py_reg[63:16]});
            out_last_reg <= s4_side_reg[0];
        end
    end

    assign out_valid   = out_vld_reg;
    assign accel_out_x = out_ax_reg;
    assign accel_out_y = out_ay_reg;
    assign vel_out_x   = out_vx_reg;
    assign vel_out_y   = out_vy_reg;
    assign pos_out_x   = out_px_reg;
    assign pos_out_y   = out_py_reg;
    assign last_out    = out_last_reg;

endmodule

`default_nettype wire
